/* design/dual_queue_shared_buffer_macros.svh */
// Assertion macros shared by the dual queue shared buffer modules.
`ifndef DUAL_QUEUE_SHARED_BUFFER_MACROS_SVH
`define DUAL_QUEUE_SHARED_BUFFER_MACROS_SVH

// Check cons in the same cycle as ante, outside reset.
`define DQSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, outside reset.
`define DQSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/dqsb_pkg.sv */
// Package with sizes, command codes, and control types of the shared buffer queues.
`timescale 1ns / 1ps
`default_nettype none

package dqsb_pkg;

  localparam int CAPACITY     = 16;
  localparam int FIRST_DEPTH  = (CAPACITY + 1) / 2;
  localparam int SECOND_DEPTH = CAPACITY / 2;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int TOT_W        = CNT_W + 1;
  localparam int FPTR_W       = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
  localparam int SPTR_W       = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
  localparam int WORD_W       = 32;
  localparam int CNT_FIELD_W  = 5;

  typedef enum logic [1:0] {
    CMD_ENQUEUE    = 2'd0,
    CMD_DEQ_FIRST  = 2'd1,
    CMD_DEQ_SECOND = 2'd2
  } cmd_code_t;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic exec;
    logic fetch_load;
  } dqsb_cmd_t;

  typedef struct packed {
    logic need_fetch;
  } dqsb_status_t;

  // Report a count modulo the width of the result field.
  function automatic logic [CNT_FIELD_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+CNT_FIELD_W-1:0] ext;
    ext = {{CNT_FIELD_W{1'b0}}, c};
    return ext[CNT_FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/dqsb_ram.sv */
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dqsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/dqsb_ctrl.sv */
// Controller state machine for the shared buffer queues.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_queue_shared_buffer_macros.svh"

module dqsb_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire dqsb_pkg::dqsb_status_t status,
  output dqsb_pkg::dqsb_cmd_t        cmd
);

  import dqsb_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    in_stall       = 1'b1;
    accept         = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        // Take a new item once the result slot is empty or drains now.
        in_stall = out_valid && out_stall;
        accept   = in_valid && !in_stall;
        cmd.exec = accept;
        if (accept) begin
          if (status.need_fetch) begin
            state_next     = ST_FETCH;
            out_valid_next = 1'b0;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch_load = 1'b1;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `DQSB_ASSERT_NEXT(a_fetch_done, state == ST_FETCH, (state == ST_IDLE) && out_valid, "fetch did not finish in one cycle")
  `DQSB_ASSERT_NEXT(a_fetch_entry, accept && status.need_fetch, (state == ST_FETCH) && !out_valid, "dequeue with remaining entries skipped the head fetch")
  `DQSB_ASSERT_NEXT(a_direct_result, accept && !status.need_fetch, out_valid && (state == ST_IDLE), "result of a direct operation not presented")

endmodule

`default_nettype wire

/* design/dqsb_dpath.sv */
// Datapath for the shared buffer queues: counts, ring pointers, head words, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_queue_shared_buffer_macros.svh"

module dqsb_dpath (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire dqsb_pkg::dqsb_cmd_t                      cmd,
  output dqsb_pkg::dqsb_status_t                        status,
  input  wire logic [1:0]                               command,
  input  wire logic signed [dqsb_pkg::WORD_W-1:0]       value,
  output logic                                          success,
  output logic                                          chosen_queue,
  output logic [dqsb_pkg::CNT_FIELD_W-1:0]              first_count,
  output logic [dqsb_pkg::CNT_FIELD_W-1:0]              second_count,
  output logic                                          first_head_valid,
  output logic signed [dqsb_pkg::WORD_W-1:0]            first_head,
  output logic                                          second_head_valid,
  output logic signed [dqsb_pkg::WORD_W-1:0]            second_head
);

  import dqsb_pkg::*;

  logic [CNT_W-1:0]  first_cnt, first_cnt_next, second_cnt, second_cnt_next;
  logic [FPTR_W-1:0] first_rd, first_rd_next, first_wr, first_wr_next;
  logic [SPTR_W-1:0] second_rd, second_rd_next, second_wr, second_wr_next;
  logic [WORD_W-1:0] first_word, first_word_next, second_word, second_word_next;
  logic              fetch_sel, fetch_sel_next;
  logic [TOT_W-1:0]  total;
  logic              full, ok, chosen;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  function automatic logic [FPTR_W-1:0] adv_first(input logic [FPTR_W-1:0] p);
    return (p == FPTR_W'(FIRST_DEPTH - 1)) ? '0 : p + FPTR_W'(1);
  endfunction

  function automatic logic [SPTR_W-1:0] adv_second(input logic [SPTR_W-1:0] p);
    return (p == SPTR_W'(SECOND_DEPTH - 1)) ? '0 : p + SPTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] first_addr(input logic [FPTR_W-1:0] p);
    return ADDR_W'(p);
  endfunction

  function automatic logic [ADDR_W-1:0] second_addr(input logic [SPTR_W-1:0] p);
    return ADDR_W'(FIRST_DEPTH) + ADDR_W'(p);
  endfunction

  dqsb_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    total             = {1'b0, first_cnt} + {1'b0, second_cnt};
    full              = total >= TOT_W'(CAPACITY);
    first_cnt_next    = first_cnt;
    second_cnt_next   = second_cnt;
    first_rd_next     = first_rd;
    first_wr_next     = first_wr;
    second_rd_next    = second_rd;
    second_wr_next    = second_wr;
    first_word_next   = first_word;
    second_word_next  = second_word;
    fetch_sel_next    = fetch_sel;
    ok                = 1'b0;
    chosen            = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = '0;
    ram_raddr         = '0;
    status.need_fetch = 1'b0;
    unique case (command)
      CMD_ENQUEUE: begin
        if (!full) begin
          ok     = 1'b1;
          ram_we = cmd.exec;
          if (first_cnt <= second_cnt) begin
            ram_waddr      = first_addr(first_wr);
            first_wr_next  = adv_first(first_wr);
            first_cnt_next = first_cnt + CNT_W'(1);
            if (first_cnt == '0) begin
              first_word_next = value;
            end
          end else begin
            chosen          = 1'b1;
            ram_waddr       = second_addr(second_wr);
            second_wr_next  = adv_second(second_wr);
            second_cnt_next = second_cnt + CNT_W'(1);
            if (second_cnt == '0) begin
              second_word_next = value;
            end
          end
        end
      end
      CMD_DEQ_FIRST: begin
        if (first_cnt != '0) begin
          ok             = 1'b1;
          first_rd_next  = adv_first(first_rd);
          first_cnt_next = first_cnt - CNT_W'(1);
          if (first_cnt_next != '0) begin
            status.need_fetch = 1'b1;
            ram_raddr         = first_addr(first_rd_next);
            fetch_sel_next    = 1'b0;
          end
        end
      end
      CMD_DEQ_SECOND: begin
        if (second_cnt != '0) begin
          ok              = 1'b1;
          second_rd_next  = adv_second(second_rd);
          second_cnt_next = second_cnt - CNT_W'(1);
          if (second_cnt_next != '0) begin
            status.need_fetch = 1'b1;
            ram_raddr         = second_addr(second_rd_next);
            fetch_sel_next    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_cnt  <= '0;
      second_cnt <= '0;
      first_rd   <= '0;
      first_wr   <= '0;
      second_rd  <= '0;
      second_wr  <= '0;
    end else if (cmd.exec) begin
      first_cnt  <= first_cnt_next;
      second_cnt <= second_cnt_next;
      first_rd   <= first_rd_next;
      first_wr   <= first_wr_next;
      second_rd  <= second_rd_next;
      second_wr  <= second_wr_next;
    end
  end

  // Head words and the result register carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      first_word        <= first_word_next;
      second_word       <= second_word_next;
      fetch_sel         <= fetch_sel_next;
      success           <= ok;
      chosen_queue      <= chosen;
      first_count       <= count_field(first_cnt_next);
      second_count      <= count_field(second_cnt_next);
      first_head_valid  <= first_cnt_next != '0;
      second_head_valid <= second_cnt_next != '0;
      first_head        <= (first_cnt_next != '0) ? first_word_next : '0;
      second_head       <= (second_cnt_next != '0) ? second_word_next : '0;
    end else if (cmd.fetch_load) begin
      if (fetch_sel) begin
        second_word <= ram_rdata;
        second_head <= ram_rdata;
      end else begin
        first_word <= ram_rdata;
        first_head <= ram_rdata;
      end
    end
  end

  `DQSB_ASSERT_NOW(a_total_bound, 1'b1, total <= TOT_W'(CAPACITY), "queues together exceed the buffer")
  `DQSB_ASSERT_NOW(a_first_bound, 1'b1, first_cnt <= CNT_W'(FIRST_DEPTH), "first queue overran its region")
  `DQSB_ASSERT_NOW(a_second_bound, 1'b1, second_cnt <= CNT_W'(SECOND_DEPTH), "second queue overran its region")

endmodule

`default_nettype wire

/* design/dual_queue_shared_buffer.sv */
// Top level of two FIFO queues sharing one buffer, shortest queue takes each enqueue.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   input   | into      | in_valid / in_stall  | command, value
//   output  | out of    | out_valid / out_stall| success, chosen_queue, counts, heads
//
// Sequence: an enqueue, a failed operation, or a dequeue that empties its queue
// registers its result when accepted; a dequeue that leaves entries behind adds
// a fetch state, for the registered read of the new head word from the buffer RAM.
// Reset: rst clears both counts and ring pointers; the buffer RAM itself is
// not cleared, since only live slots are ever read.
// Stalls: a new transfer is taken while the previous result sits in the output
// register if that result drains in the same cycle; otherwise hold the input.
`timescale 1ns / 1ps
`default_nettype none

module dual_queue_shared_buffer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          command,
  input  wire logic signed [dqsb_pkg::WORD_W-1:0]  value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     success,
  output logic                                     chosen_queue,
  output logic [dqsb_pkg::CNT_FIELD_W-1:0]         first_count,
  output logic [dqsb_pkg::CNT_FIELD_W-1:0]         second_count,
  output logic                                     first_head_valid,
  output logic signed [dqsb_pkg::WORD_W-1:0]       first_head,
  output logic                                     second_head_valid,
  output logic signed [dqsb_pkg::WORD_W-1:0]       second_head
);

  import dqsb_pkg::*;

  // Command and status between the controller and the datapath.
  dqsb_cmd_t    cmd;
  dqsb_status_t status;

  // Controller: decide when to accept, when to capture a fetched head word,
  // and when the result register holds a finished transfer.
  dqsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: the first queue rings through the low region of the RAM and the
  // second through the high region; the head words are cached in registers.
  dqsb_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .command          (command),
    .value            (value),
    .success          (success),
    .chosen_queue     (chosen_queue),
    .first_count      (first_count),
    .second_count     (second_count),
    .first_head_valid (first_head_valid),
    .first_head       (first_head),
    .second_head_valid(second_head_valid),
    .second_head      (second_head)
  );

endmodule

`default_nettype wire
